// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL that checks its own logic.
// Each macro expands to one labeled concurrent assertion on clk with rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in one cycle requires the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/evzc_pkg.sv =====
// ----------------------------------------------------------------------------
// evzc_pkg
// Shared types and constants of the energy / zero-crossing voice detector.
// ----------------------------------------------------------------------------
package evzc_pkg;

    // Frame geometry: a frame closes on its flag or at this many samples.
    localparam int MAX_FRAME = 512;
    localparam int LEN_W     = $clog2(MAX_FRAME);

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int ENERGY_W = 32;
    localparam int CROSS_W  = 10;
    localparam int HANG_W   = 8;
    localparam int INDEX_W  = 3;
    localparam int DATA_W   = 32;

    // Register indexes on the configuration port.
    localparam logic [INDEX_W-1:0] REG_ENERGY_HIGH    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_ENERGY_LOW     = 3'd1;
    localparam logic [INDEX_W-1:0] REG_CROSSINGS_HIGH = 3'd2;
    localparam logic [INDEX_W-1:0] REG_CROSSINGS_LOW  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_HANGOVER       = 3'd4;

    // Register reset values.
    localparam logic [ENERGY_W-1:0] ENERGY_HIGH_RST    = 32'd50000;
    localparam logic [ENERGY_W-1:0] ENERGY_LOW_RST     = 32'd10000;
    localparam logic [CROSS_W-1:0]  CROSSINGS_HIGH_RST = 10'd10;
    localparam logic [CROSS_W-1:0]  CROSSINGS_LOW_RST  = 10'd1;
    localparam logic [HANG_W-1:0]   HANGOVER_RST       = 8'd60;

    // Thresholds seen by the decision stage.
    typedef struct packed {
        logic [ENERGY_W-1:0] energy_high;
        logic [ENERGY_W-1:0] energy_low;
        logic [CROSS_W-1:0]  crossings_high;
        logic [CROSS_W-1:0]  crossings_low;
        logic [HANG_W-1:0]   hangover_frames;
    } cfg_t;

    // Figures of one closed frame.
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [CROSS_W-1:0]  crossings;
    } frame_t;

    // Status of the accumulation stage.
    typedef struct packed {
        logic             in_valid;
        logic [LEN_W-1:0] frame_len;
    } acc_status_t;

endpackage

// ===== rtl/evzc_sample_if.sv =====
// ----------------------------------------------------------------------------
// evzc_sample_if
// Sample channel: one PCM sample and its frame-end flag per request.
// ----------------------------------------------------------------------------
interface evzc_sample_if
    import evzc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

// ===== rtl/evzc_result_if.sv =====
// ----------------------------------------------------------------------------
// evzc_result_if
// Result channel: one voice decision and the frame figures per request.
// ----------------------------------------------------------------------------
interface evzc_result_if
    import evzc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                voice_active;
    logic [ENERGY_W-1:0] frame_energy;
    logic [CROSS_W-1:0]  frame_crossings;

    modport source (output valid, output voice_active, output frame_energy,
                    output frame_crossings, input ready);
    modport sink   (input valid, input voice_active, input frame_energy,
                    input frame_crossings, output ready);
endinterface

// ===== rtl/evzc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// evzc_cfg_if
// Configuration write channel: register index and write data per request.
// ----------------------------------------------------------------------------
interface evzc_cfg_if
    import evzc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/energy_zero_crossing_vad_core.sv =====
// ----------------------------------------------------------------------------
// energy_zero_crossing_vad_core
// Energy / zero-crossing voice activity detector, one result per frame.
// ----------------------------------------------------------------------------
//  Channel    Direction  Request carries
//  samples    in         sample, frame_end
//  decisions  out        voice_active, frame_energy, frame_crossings
//  cfg        in         index, data (register write)
//
//  One sample is taken per cycle unless a closing sample waits for a full
//  record register. Samples are held in the input register, then added into
//  the frame accumulators; results pass the record and result registers.
//  Reset restores register defaults and clears state; no clearing pass.
//  Stalls on decisions back up through the record and input registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module energy_zero_crossing_vad_core
    import evzc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    evzc_sample_if.sink   samples,
    evzc_result_if.source decisions,
    evzc_cfg_if.sink      cfg
);

    cfg_t        cfg_reg;
    logic        rec_valid;
    frame_t      rec;
    logic        rec_ready;
    acc_status_t acc_status;

    // Configuration registers; writes are always accepted.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.energy_high     <= ENERGY_HIGH_RST;
            cfg_reg.energy_low      <= ENERGY_LOW_RST;
            cfg_reg.crossings_high  <= CROSSINGS_HIGH_RST;
            cfg_reg.crossings_low   <= CROSSINGS_LOW_RST;
            cfg_reg.hangover_frames <= HANGOVER_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ENERGY_HIGH:    cfg_reg.energy_high     <= cfg.data;
                REG_ENERGY_LOW:     cfg_reg.energy_low      <= cfg.data;
                REG_CROSSINGS_HIGH: cfg_reg.crossings_high  <= cfg.data[CROSS_W-1:0];
                REG_CROSSINGS_LOW:  cfg_reg.crossings_low   <= cfg.data[CROSS_W-1:0];
                REG_HANGOVER:       cfg_reg.hangover_frames <= cfg.data[HANG_W-1:0];
                default:            ;
            endcase
        end
    end

    // Per-sample accumulation.
    evzc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready),
        .status    (acc_status)
    );

    // Per-frame decision.
    evzc_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready),
        .results   (decisions)
    );

    // The frame length counter stays below the maximum frame length.
    `ASSERT_ALWAYS(a_len_bound, acc_status.frame_len <= LEN_W'(MAX_FRAME - 1),
        "frame length counter out of range")

    // A record taken by the decision stage shows up as a result next cycle.
    `ASSERT_NEXT(a_rec_to_out, rec_valid && rec_ready, decisions.valid,
        "frame record lost on its way to the result register")

    // A loud, busy frame always leaves the detector in voice state.
    `ASSERT_NEXT(a_loud_voice,
        rec_valid && rec_ready && (rec.energy > cfg_reg.energy_high)
            && (rec.crossings > cfg_reg.crossings_high) && !cfg.valid,
        decisions.voice_active,
        "voice frame did not set voice state")

    // The input register only refuses a sample while it holds one.
    `ASSERT_ALWAYS(a_in_ready, !samples.ready |-> acc_status.in_valid,
        "sample refused with empty input register")

endmodule

// ===== rtl/evzc_accum.sv =====
// ----------------------------------------------------------------------------
// evzc_accum
// Input register and per-frame accumulation of energy and sign changes.
// Emits one frame record into a holding register when a frame closes.
// ----------------------------------------------------------------------------
module evzc_accum
    import evzc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    evzc_sample_if.sink samples,
    output logic        rec_valid,
    output frame_t      rec,
    input  logic        rec_ready,
    output acc_status_t status
);

    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_last_reg;

    logic [ENERGY_W-1:0]        energy_reg;
    logic [CROSS_W-1:0]         cross_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic [LEN_W-1:0]           len_reg;

    logic                       rec_valid_reg;
    frame_t                     rec_reg;

    logic [SAMPLE_W-1:0]        mag;
    logic [ENERGY_W:0]          energy_sum;
    logic [ENERGY_W-1:0]        energy_next;
    logic                       prev_pos;
    logic                       prev_neg;
    logic                       cur_pos;
    logic                       cur_neg;
    logic                       change;
    logic [CROSS_W-1:0]         cross_next;
    logic [LEN_W:0]             len_inc;
    logic                       close;
    logic                       rec_free;
    logic                       take;

    // Magnitude; the most negative sample maps to 32768, which fits unsigned.
    assign mag = in_sample_reg[SAMPLE_W-1] ? (~in_sample_reg + 1'b1) : in_sample_reg;

    // Saturating energy sum.
    assign energy_sum  = {1'b0, energy_reg} + {{(ENERGY_W + 1 - SAMPLE_W){1'b0}}, mag};
    assign energy_next = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];

    // Strict sign change against the previous sample of the same frame.
    assign prev_pos = !prev_reg[SAMPLE_W-1] && (prev_reg != '0);
    assign prev_neg = prev_reg[SAMPLE_W-1];
    assign cur_pos  = !in_sample_reg[SAMPLE_W-1] && (in_sample_reg != '0);
    assign cur_neg  = in_sample_reg[SAMPLE_W-1];
    assign change   = (len_reg != '0) && ((prev_pos && cur_neg) || (prev_neg && cur_pos));
    assign cross_next = (change && (cross_reg != '1)) ? cross_reg + 1'b1 : cross_reg;

    // Frame closes on the flag or when it reaches its maximum length.
    assign len_inc = {1'b0, len_reg} + 1'b1;
    assign close   = in_last_reg || (len_inc == (LEN_W + 1)'(MAX_FRAME));

    // Handshakes between input register, accumulator and record register.
    assign rec_free      = !rec_valid_reg || rec_ready;
    assign take          = in_valid_reg && (!close || rec_free);
    assign samples.ready = !in_valid_reg || take;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_sample_reg <= samples.sample;
            in_last_reg   <= samples.frame_end;
        end
    end

    // Frame accumulators; cleared when a frame closes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            cross_reg  <= '0;
            prev_reg   <= '0;
            len_reg    <= '0;
        end
        else if (take)
        begin
            if (close)
            begin
                energy_reg <= '0;
                cross_reg  <= '0;
                prev_reg   <= '0;
                len_reg    <= '0;
            end
            else
            begin
                energy_reg <= energy_next;
                cross_reg  <= cross_next;
                prev_reg   <= in_sample_reg;
                len_reg    <= len_inc[LEN_W-1:0];
            end
        end
    end

    // Record register holding the figures of a closed frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
        end
        else if (rec_free)
        begin
            rec_valid_reg <= take && close;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && close)
        begin
            rec_reg.energy    <= energy_next;
            rec_reg.crossings <= cross_next;
        end
    end

    assign rec_valid        = rec_valid_reg;
    assign rec              = rec_reg;
    assign status.in_valid  = in_valid_reg;
    assign status.frame_len = len_reg;

endmodule

// ===== rtl/evzc_decide.sv =====
// ----------------------------------------------------------------------------
// evzc_decide
// Voice / silence decision with hangover, and the result register.
// ----------------------------------------------------------------------------
module evzc_decide
    import evzc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          rec_valid,
    input  frame_t        rec,
    output logic          rec_ready,
    evzc_result_if.source results
);

    logic                voice_reg;
    logic                voice_next;
    logic [HANG_W-1:0]   silence_reg;
    logic [HANG_W-1:0]   silence_next;
    logic                out_valid_reg;
    logic [ENERGY_W-1:0] out_energy_reg;
    logic [CROSS_W-1:0]  out_cross_reg;
    logic                loud;
    logic                quiet;
    logic                rec_take;

    assign rec_ready = !out_valid_reg || results.ready;
    assign rec_take  = rec_valid && rec_ready;

    // Threshold compares on the closed frame.
    assign loud  = (rec.energy > cfg.energy_high) && (rec.crossings > cfg.crossings_high);
    assign quiet = (rec.energy < cfg.energy_low) || (rec.crossings < cfg.crossings_low);

    // Next voice state and hangover count.
    always_comb
    begin
        voice_next   = voice_reg;
        silence_next = silence_reg;
        if (loud)
        begin
            voice_next   = 1'b1;
            silence_next = '0;
        end
        else if (quiet)
        begin
            if (voice_reg && (silence_reg < cfg.hangover_frames))
            begin
                silence_next = silence_reg + 1'b1;
            end
            else
            begin
                voice_next   = 1'b0;
                silence_next = '0;
            end
        end
    end

    // Detector state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_reg     <= 1'b0;
            silence_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rec_take)
            begin
                voice_reg   <= voice_next;
                silence_reg <= silence_next;
            end
            if (rec_ready)
            begin
                out_valid_reg <= rec_valid;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            out_energy_reg <= rec.energy;
            out_cross_reg  <= rec.crossings;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.voice_active    = voice_reg;
    assign results.frame_energy    = out_energy_reg;
    assign results.frame_crossings = out_cross_reg;

endmodule

// ===== bench/tb_energy_zero_crossing_vad_core.sv =====
// ----------------------------------------------------------------------------
// tb_energy_zero_crossing_vad_core
// Self-checking bench for the energy / zero-crossing voice activity detector.
// PCM frames of voiced, quiet and noisy shape are streamed through the block
// under several threshold settings. A scoreboard tracks the frame figures and
// the voice / hangover state, then checks every decision field by field.
// ----------------------------------------------------------------------------
module tb_energy_zero_crossing_vad_core
    import evzc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let pass after the last decision before touching registers.
    localparam int SETTLE_CYCLES = 6;

    typedef enum {FRAME_VOICED, FRAME_QUIET, FRAME_NOISE} frame_kind_t;

    // Tracks frame accumulation and the voice decision for each closed frame.
    class vad_scoreboard;
        typedef struct {
            bit                voice;
            bit [ENERGY_W-1:0] energy;
            bit [CROSS_W-1:0]  crossings;
        } decision_t;

        bit [ENERGY_W-1:0] energy_high;
        bit [ENERGY_W-1:0] energy_low;
        bit [CROSS_W-1:0]  crossings_high;
        bit [CROSS_W-1:0]  crossings_low;
        bit [HANG_W-1:0]   hangover_frames;

        bit                voice_state;
        bit [HANG_W-1:0]   silent_run;
        bit [ENERGY_W-1:0] energy_acc;
        bit [CROSS_W-1:0]  crossing_acc;
        int                prev_sample;
        bit                at_frame_start;
        int                frame_len;

        decision_t expected_decisions[$];
        int        errors;
        int        samples_seen;
        int        frames_closed;
        int        voiced_frames;

        function new();
            energy_high     = ENERGY_HIGH_RST;
            energy_low      = ENERGY_LOW_RST;
            crossings_high  = CROSSINGS_HIGH_RST;
            crossings_low   = CROSSINGS_LOW_RST;
            hangover_frames = HANGOVER_RST;
            at_frame_start  = 1'b1;
        endfunction

        // Register write; indexes outside the map are dropped.
        function void write_reg(logic [INDEX_W-1:0] index, logic [DATA_W-1:0] data);
            case (index)
                REG_ENERGY_HIGH:    energy_high     = data[ENERGY_W-1:0];
                REG_ENERGY_LOW:     energy_low      = data[ENERGY_W-1:0];
                REG_CROSSINGS_HIGH: crossings_high  = data[CROSS_W-1:0];
                REG_CROSSINGS_LOW:  crossings_low   = data[CROSS_W-1:0];
                REG_HANGOVER:       hangover_frames = data[HANG_W-1:0];
                default: ;
            endcase
        endfunction

        // Accumulates one accepted sample and queues a decision on frame close.
        function void note_sample(logic signed [SAMPLE_W-1:0] s, logic last);
            int                value;
            bit [ENERGY_W-1:0] mag;
            bit [ENERGY_W:0]   sum;
            decision_t         d;
            value = s;
            mag   = (value < 0) ? -value : value;
            sum   = energy_acc + mag;
            energy_acc = sum[ENERGY_W] ? '1 : sum[ENERGY_W-1:0];
            samples_seen++;

            // A zero on either side never counts as a sign change.
            if (!at_frame_start && crossing_acc != '1 &&
                ((prev_sample > 0 && value < 0) || (prev_sample < 0 && value > 0)))
                crossing_acc++;
            prev_sample    = value;
            at_frame_start = 1'b0;
            if (frame_len < MAX_FRAME)
                frame_len++;

            // Overlong frames close on their last allowed sample.
            if (!last && frame_len < MAX_FRAME)
                return;

            if (energy_acc > energy_high && crossing_acc > crossings_high) begin
                voice_state = 1'b1;
                silent_run  = '0;
            end
            else if (energy_acc < energy_low || crossing_acc < crossings_low) begin
                if (silent_run < hangover_frames && voice_state)
                    silent_run++;
                else begin
                    voice_state = 1'b0;
                    silent_run  = '0;
                end
            end

            d.voice     = voice_state;
            d.energy    = energy_acc;
            d.crossings = crossing_acc;
            expected_decisions.push_back(d);
            frames_closed++;

            energy_acc     = '0;
            crossing_acc   = '0;
            prev_sample    = 0;
            at_frame_start = 1'b1;
            frame_len      = 0;
        endfunction

        // Compares one accepted decision with the oldest pending frame.
        function void check_decision(logic voice, logic [ENERGY_W-1:0] energy,
                                     logic [CROSS_W-1:0] crossings);
            decision_t d;
            if (expected_decisions.size() == 0) begin
                $error({"decision with no frame pending: voice_active %0d, ",
                        "frame_energy %0d, frame_crossings %0d"},
                       voice, energy, crossings);
                errors++;
                return;
            end
            d = expected_decisions.pop_front();
            if (voice !== d.voice) begin
                $error("voice_active: expected %0d, actual %0d", d.voice, voice);
                errors++;
            end
            if (energy !== d.energy) begin
                $error("frame_energy: expected %0d, actual %0d", d.energy, energy);
                errors++;
            end
            if (crossings !== d.crossings) begin
                $error("frame_crossings: expected %0d, actual %0d", d.crossings, crossings);
                errors++;
            end
            if (d.voice)
                voiced_frames++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_gaps;

    evzc_sample_if samples_ch ();
    evzc_result_if decisions_ch ();
    evzc_cfg_if    cfg_ch ();

    vad_scoreboard board = new();

    energy_zero_crossing_vad_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch),
        .decisions (decisions_ch),
        .cfg       (cfg_ch)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Random gap decision shared by both sides of the block.
    function automatic bit take_gap();
        return !no_gaps && $urandom_range(99) < 11;
    endfunction

    // Downstream ready with random stalls.
    initial
    begin
        decisions_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            decisions_ch.ready = !take_gap();
        end
    end

    // Decision monitor.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && decisions_ch.valid && decisions_ch.ready)
                board.check_decision(decisions_ch.voice_active, decisions_ch.frame_energy,
                                     decisions_ch.frame_crossings);
        end
    end

    // Drives one sample request and waits for it to be taken.
    task automatic send_sample(input int value, input bit last);
        @(negedge clk);
        while (take_gap())
        begin
            samples_ch.valid = 1'b0;
            @(negedge clk);
        end
        samples_ch.valid     = 1'b1;
        samples_ch.sample    = value[SAMPLE_W-1:0];
        samples_ch.frame_end = last;
        do @(posedge clk); while (!samples_ch.ready);
        board.note_sample(samples_ch.sample, last);
    endtask

    // Drives one register write request.
    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [DATA_W-1:0] data);
        @(negedge clk);
        while (take_gap())
        begin
            cfg_ch.valid = 1'b0;
            @(negedge clk);
        end
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = data;
        do @(posedge clk); while (!cfg_ch.ready);
        board.write_reg(index, data);
    endtask

    // Loads all five thresholds; narrow registers get random upper data bits.
    task automatic set_thresholds(input logic [ENERGY_W-1:0] e_high,
                                  input logic [ENERGY_W-1:0] e_low,
                                  input logic [CROSS_W-1:0] c_high,
                                  input logic [CROSS_W-1:0] c_low,
                                  input logic [HANG_W-1:0] hang);
        write_reg(REG_ENERGY_HIGH, e_high);
        write_reg(REG_ENERGY_LOW, e_low);
        write_reg(REG_CROSSINGS_HIGH, ($urandom << CROSS_W) | c_high);
        write_reg(REG_CROSSINGS_LOW, ($urandom << CROSS_W) | c_low);
        write_reg(REG_HANGOVER, ($urandom << HANG_W) | hang);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Stops sending and waits until every pending decision has arrived.
    task automatic settle();
        @(negedge clk);
        samples_ch.valid = 1'b0;
        while (board.expected_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sample of the given frame shape at position pos.
    function automatic int make_sample(frame_kind_t kind, int pos, bit neg_first);
        int mag;
        case (kind)
            FRAME_VOICED:
            begin
                if ($urandom_range(7) == 0)
                    return 0;
                mag = $urandom_range(32768, 800);
                if ((pos % 2 == 1) ^ neg_first)
                    return -mag;
                return (mag > 32767) ? 32767 : mag;
            end
            FRAME_QUIET:
            begin
                mag = $urandom_range(300);
                if ($urandom_range(15) == 0)
                    neg_first = !neg_first;
                return neg_first ? -mag : mag;
            end
            default:
                return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    task automatic send_frame(input frame_kind_t kind, input int len, input bit close);
        bit neg_first;
        neg_first = 1'($urandom_range(1));
        for (int i = 0; i < len; i++)
            send_sample(make_sample(kind, i, neg_first), close && i == len - 1);
    endtask

    // Random frames: mostly voiced and quiet runs, some noise and unflagged frames.
    task automatic run_frames(input int n_samples);
        int          sent;
        int          len;
        int          roll;
        bit          close;
        frame_kind_t kind;
        sent = 0;
        while (sent < n_samples)
        begin
            roll = $urandom_range(99);
            kind = (roll < 45) ? FRAME_VOICED : (roll < 80) ? FRAME_QUIET : FRAME_NOISE;
            len  = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4);
            sent += len;
            close = sent >= n_samples || $urandom_range(19) != 0;
            send_frame(kind, len, close);
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n                = 1'b0;
        samples_ch.valid     = 1'b0;
        samples_ch.sample    = '0;
        samples_ch.frame_end = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames at reset thresholds: single-sample extremes,
        // zeros between signs, a short crossing run, a voiced frame and
        // a silent frame that starts the hangover count.
        send_sample(32767, 1'b1);
        send_sample(-32768, 1'b1);
        send_sample(0, 1'b1);
        send_sample(7, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-7, 1'b0);
        send_sample(0, 1'b0);
        send_sample(7, 1'b1);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(-1, 1'b1);
        for (int i = 0; i < 13; i++)
            send_sample((i % 2) ? -20000 : 20000, i == 12);
        send_sample(0, 1'b1);
        settle();

        // Reset thresholds, an overlong frame, and a full pause mid-stream.
        run_frames(70);
        send_frame(FRAME_NOISE, MAX_FRAME, 1'b0);
        settle();
        run_frames(70);
        settle();

        // Low random thresholds, with no gaps on either side.
        no_gaps = 1'b1;
        set_thresholds($urandom_range(60000), $urandom_range(20000),
                       CROSS_W'($urandom_range(8)), CROSS_W'($urandom_range(4)),
                       HANG_W'($urandom_range(4)));
        run_frames(100);
        settle();
        no_gaps = 1'b0;

        // All thresholds at their minimum.
        set_thresholds('0, '0, '0, '0, '0);
        run_frames(60);
        settle();

        // All thresholds at their maximum, plus writes to unmapped indexes.
        set_thresholds('1, '1, '1, '1, '1);
        for (int i = 0; i < 4; i++)
            write_reg(INDEX_W'($urandom_range((1 << INDEX_W) - 1, REG_HANGOVER + 1)),
                      $urandom);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        run_frames(60);
        settle();

        // Moderate thresholds with the longest hangover.
        set_thresholds($urandom_range(200000, 20000), $urandom_range(40000),
                       CROSS_W'($urandom_range(20, 2)), CROSS_W'($urandom_range(3)), '1);
        run_frames(60);
        settle();

        if (board.expected_decisions.size() != 0)
        begin
            $error("%0d frame decisions never arrived", board.expected_decisions.size());
            board.errors++;
        end
        $display("Streamed %0d samples in %0d frames under five threshold settings,",
                 board.samples_seen, board.frames_closed);
        $display("including reset values and both extremes; %0d frames ended in voice.",
                 board.voiced_frames);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
